// ===== src/status_led_pattern_generator_assert.svh =====
// Assertion macros for the status LED pattern generator.
`ifndef STATUS_LED_PATTERN_GENERATOR_ASSERT_SVH
`define STATUS_LED_PATTERN_GENERATOR_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SLPG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("status LED pattern check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define SLPG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("status LED pattern check failed");

`endif

// ===== src/slpg_pkg.sv =====
// Types and constants shared by the status LED pattern generator.
package slpg_pkg;

    localparam int TIME_W = 32;
    localparam int CNT_W = $clog2(TIME_W);
    localparam int HALF_W = 16;
    localparam int FLASH_LEFT_W = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EVAL,
        ST_HOLD
    } t_state;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_MODE = 2'd1;
    localparam logic [1:0] KIND_ACT = 2'd2;
    localparam logic [1:0] KIND_FLASH = 2'd3;

    localparam logic [1:0] MODE_NETWORK = 2'd0;
    localparam logic [1:0] MODE_SERVER = 2'd1;
    localparam logic [1:0] MODE_IDLE = 2'd2;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_BUTTON = 2'd1;
    localparam logic [1:0] ACT_SHORT = 2'd2;
    localparam logic [1:0] ACT_LONG = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_HALF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_HALF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_PERIOD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_BLIP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STROBE_HALF = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_HALF = 3'd6;

    localparam logic [HALF_W-1:0] RST_FAST_HALF = 16'd100;
    localparam logic [HALF_W-1:0] RST_SLOW_HALF = 16'd600;
    localparam logic [HALF_W-1:0] RST_IDLE_PERIOD = 16'd4000;
    localparam logic [HALF_W-1:0] RST_IDLE_BLIP = 16'd40;
    localparam logic [HALF_W-1:0] RST_STROBE_HALF = 16'd60;
    localparam logic [HALF_W-1:0] RST_FLASH_HALF = 16'd120;

endpackage

// ===== src/status_led_pattern_generator.sv =====
// Status LED pattern generator: tick and command processing with a bit-serial divider.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+--------------------------------------
//  item in  | input     | i_in_valid / o_in_stall    | kind, mode, activity, flash count
//  item out | output    | o_out_valid / i_out_stall  | led on, pin level, pin changed
//  config   | input     | i_cfg_wr_en                | register index, register data
//
// A tick that needs the divider (square wave or idle blip) passes through ST_DIV, one dividend
// bit per cycle, then ST_EVAL and ST_HOLD before its result is loaded into the output register.
// Commands and ticks decided without a division go from ST_IDLE to ST_HOLD, then to the output register.
// One item is in work at a time; the output register lets a new item enter while a result waits.
// Reset is synchronous and loads the default register values and the idle mode.
// A stalled result holds in the output register, and the engine waits if it is still full.
`include "status_led_pattern_generator_assert.svh"

module status_led_pattern_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [1:0]                       i_kind,
    input  logic [1:0]                       i_mode_value,
    input  logic [1:0]                       i_activity_value,
    input  logic [7:0]                       i_flash_count,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_led_on,
    output logic                             o_pin_level,
    output logic                             o_pin_changed,
    input  logic                             i_cfg_wr_en,
    input  logic [slpg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [slpg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import slpg_pkg::*;

    t_state                  r_state, n_state;
    logic                    r_active_low;
    logic [HALF_W-1:0]       r_fast_half, r_slow_half, r_idle_period, r_idle_blip;
    logic [HALF_W-1:0]       r_strobe_half, r_flash_half;
    logic [TIME_W-1:0]       r_phase, n_phase;
    logic [TIME_W-1:0]       r_flash, n_flash;
    logic [FLASH_LEFT_W-1:0] r_flash_left, n_flash_left;
    logic [1:0]              r_mode, n_mode;
    logic [1:0]              r_activity, n_activity;
    logic                    r_last_lit, n_last_lit;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_out_valid, n_out_valid;

    logic [TIME_W-1:0]       r_dvd, n_dvd;
    logic [HALF_W-1:0]       r_dsr, n_dsr;
    logic [HALF_W-1:0]       r_rem, n_rem;
    logic                    r_qbit, n_qbit;
    logic                    r_sel_idle, n_sel_idle;
    logic                    r_hold_lit, n_hold_lit;
    logic                    r_hold_chg, n_hold_chg;
    logic                    r_out_led, n_out_led;
    logic                    r_out_pin, n_out_pin;
    logic                    r_out_chg, n_out_chg;

    logic                    accept;
    logic                    load_out;
    logic [TIME_W-1:0]       phase_inc, flash_inc;
    logic [FLASH_LEFT_W-1:0] left_dec;
    logic [HALF_W:0]         rem_sh;
    logic                    rem_ge;
    logic                    v_lit, v_start_div, v_idle_sel;
    logic [HALF_W-1:0]       v_half;

    assign accept = i_in_valid && (r_state == ST_IDLE);
    assign load_out = (r_state == ST_HOLD) && (!r_out_valid || !i_out_stall);
    assign phase_inc = r_phase + TIME_W'(1);
    assign flash_inc = r_flash + TIME_W'(1);
    assign left_dec = r_flash_left - FLASH_LEFT_W'(1);
    assign rem_sh = {r_rem, r_dvd[TIME_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dsr};

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        n_flash = r_flash;
        n_flash_left = r_flash_left;
        n_mode = r_mode;
        n_activity = r_activity;
        n_last_lit = r_last_lit;
        n_cnt = r_cnt;
        n_dvd = r_dvd;
        n_dsr = r_dsr;
        n_rem = r_rem;
        n_qbit = r_qbit;
        n_sel_idle = r_sel_idle;
        n_hold_lit = r_hold_lit;
        n_hold_chg = r_hold_chg;
        n_out_led = r_out_led;
        n_out_pin = r_out_pin;
        n_out_chg = r_out_chg;
        n_out_valid = r_out_valid;
        v_lit = r_last_lit;
        v_start_div = 1'b0;
        v_idle_sel = 1'b0;
        v_half = r_fast_half;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_TICK: begin
                            n_phase = phase_inc;
                            n_flash = flash_inc;
                            if ((r_activity == ACT_BUTTON) || (r_activity == ACT_SHORT)) begin
                                v_lit = 1'b1;
                            end else if (r_activity == ACT_LONG) begin
                                v_start_div = 1'b1;
                                v_half = r_strobe_half;
                            end else if (r_flash_left != '0) begin
                                if (flash_inc >= TIME_W'(r_flash_half)) begin
                                    n_flash = '0;
                                    n_flash_left = left_dec;
                                    if (left_dec == '0) begin
                                        n_phase = '0;
                                    end
                                    v_lit = (left_dec != '0) && !left_dec[0];
                                end else begin
                                    v_lit = !r_flash_left[0];
                                end
                            end else begin
                                v_start_div = 1'b1;
                                if (r_mode == MODE_NETWORK) begin
                                    v_half = r_fast_half;
                                end else if (r_mode == MODE_SERVER) begin
                                    v_half = r_slow_half;
                                end else begin
                                    v_half = r_idle_period;
                                    v_idle_sel = 1'b1;
                                end
                            end
                        end
                        KIND_MODE: begin
                            if ((i_mode_value <= MODE_IDLE) && (i_mode_value != r_mode)) begin
                                n_mode = i_mode_value;
                                n_phase = '0;
                            end
                        end
                        KIND_ACT: begin
                            if (i_activity_value != r_activity) begin
                                n_activity = i_activity_value;
                                n_phase = '0;
                            end
                        end
                        default: begin
                            n_flash_left = {1'b0, i_flash_count, 1'b1};
                            n_flash = '0;
                        end
                    endcase

                    if (v_start_div) begin
                        n_dvd = phase_inc;
                        n_dsr = (v_half == '0) ? HALF_W'(1) : v_half;
                        n_rem = '0;
                        n_cnt = '0;
                        n_sel_idle = v_idle_sel;
                        n_state = ST_DIV;
                    end else begin
                        n_hold_lit = v_lit;
                        n_hold_chg = v_lit ^ r_last_lit;
                        n_last_lit = v_lit;
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_DIV: begin
                n_dvd = {r_dvd[TIME_W-2:0], 1'b0};
                n_qbit = rem_ge;
                n_rem = rem_ge ? HALF_W'(rem_sh - {1'b0, r_dsr}) : HALF_W'(rem_sh);
                if (r_cnt == CNT_W'(TIME_W - 1)) begin
                    n_cnt = '0;
                    n_state = ST_EVAL;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_EVAL: begin
                v_lit = r_sel_idle ? (r_rem < r_idle_blip) : !r_qbit;
                n_hold_lit = v_lit;
                n_hold_chg = v_lit ^ r_last_lit;
                n_last_lit = v_lit;
                n_state = ST_HOLD;
            end
            ST_HOLD: begin
                if (load_out) begin
                    n_out_led = r_hold_lit;
                    n_out_pin = r_hold_lit ^ r_active_low;
                    n_out_chg = r_hold_chg;
                    n_out_valid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= '0;
            r_flash <= '0;
            r_flash_left <= '0;
            r_mode <= MODE_IDLE;
            r_activity <= ACT_NONE;
            r_last_lit <= 1'b0;
            r_cnt <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_flash <= n_flash;
            r_flash_left <= n_flash_left;
            r_mode <= n_mode;
            r_activity <= n_activity;
            r_last_lit <= n_last_lit;
            r_cnt <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_low <= 1'b0;
            r_fast_half <= RST_FAST_HALF;
            r_slow_half <= RST_SLOW_HALF;
            r_idle_period <= RST_IDLE_PERIOD;
            r_idle_blip <= RST_IDLE_BLIP;
            r_strobe_half <= RST_STROBE_HALF;
            r_flash_half <= RST_FLASH_HALF;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ACTIVE_LOW:  r_active_low <= i_cfg_data[0];
                CFG_FAST_HALF:   r_fast_half <= i_cfg_data;
                CFG_SLOW_HALF:   r_slow_half <= i_cfg_data;
                CFG_IDLE_PERIOD: r_idle_period <= i_cfg_data;
                CFG_IDLE_BLIP:   r_idle_blip <= i_cfg_data;
                CFG_STROBE_HALF: r_strobe_half <= i_cfg_data;
                CFG_FLASH_HALF:  r_flash_half <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
        r_qbit <= n_qbit;
        r_sel_idle <= n_sel_idle;
        r_hold_lit <= n_hold_lit;
        r_hold_chg <= n_hold_chg;
        r_out_led <= n_out_led;
        r_out_pin <= n_out_pin;
        r_out_chg <= n_out_chg;
    end

    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_led_on = r_out_led;
    assign o_pin_level = r_out_pin;
    assign o_pin_changed = r_out_chg;

    `SLPG_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall)
    `SLPG_ASSERT_NOW(a_cnt_idle_outside_div, r_state != ST_DIV, r_cnt == '0)
    `SLPG_ASSERT_NOW(a_hold_matches_last, r_state == ST_HOLD, r_hold_lit == r_last_lit)

endmodule

// ===== bench/led_pattern_checker.sv =====
// Checker for the status LED pattern generator: predicts each result and compares it.
module led_pattern_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [1:0]                       i_kind,
    input  logic [1:0]                       i_mode_value,
    input  logic [1:0]                       i_activity_value,
    input  logic [7:0]                       i_flash_count,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_led_on,
    input  logic                             i_pin_level,
    input  logic                             i_pin_changed,
    input  logic                             i_cfg_wr_en,
    input  logic [slpg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [slpg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output int                               o_mismatches,
    output int                               o_pending,
    output int                               o_results,
    output int                               o_level_changes
);
    import slpg_pkg::*;

    typedef struct packed {
        logic led_on;
        logic pin_level;
        logic pin_changed;
    } t_led_result;

    t_led_result expected_q[$];

    logic                    active_low;
    logic [HALF_W-1:0]       fast_half;
    logic [HALF_W-1:0]       slow_half;
    logic [HALF_W-1:0]       idle_len;
    logic [HALF_W-1:0]       blip_len;
    logic [HALF_W-1:0]       strobe_len;
    logic [HALF_W-1:0]       flash_len;

    logic [TIME_W-1:0]       phase_ticks;
    logic [TIME_W-1:0]       flash_ticks;
    logic [FLASH_LEFT_W-1:0] flashes_left;
    logic [1:0]              mode_now;
    logic [1:0]              activity_now;
    logic                    lit_now;

    function automatic logic square_on(input logic [TIME_W-1:0] t,
                                       input logic [HALF_W-1:0] half);
        logic [TIME_W-1:0] quotient;
        quotient = t / ((half == '0) ? TIME_W'(1) : TIME_W'(half));
        return !quotient[0];
    endfunction

    task automatic pattern_level(output logic lit);
        logic [HALF_W-1:0] period;
        period = (idle_len == '0) ? HALF_W'(1) : idle_len;
        if (activity_now == ACT_BUTTON || activity_now == ACT_SHORT) begin
            lit = 1'b1;
        end else if (activity_now == ACT_LONG) begin
            lit = square_on(phase_ticks, strobe_len);
        end else if (flashes_left != '0) begin
            if (flash_ticks >= TIME_W'(flash_len)) begin
                flash_ticks = '0;
                flashes_left = flashes_left - FLASH_LEFT_W'(1);
                if (flashes_left == '0) begin
                    phase_ticks = '0;
                end
            end
            lit = (flashes_left != '0) && !flashes_left[0];
        end else if (mode_now == MODE_NETWORK) begin
            lit = square_on(phase_ticks, fast_half);
        end else if (mode_now == MODE_SERVER) begin
            lit = square_on(phase_ticks, slow_half);
        end else begin
            lit = (phase_ticks % TIME_W'(period)) < TIME_W'(blip_len);
        end
    endtask

    task automatic predict_item(input logic [1:0] kind, input logic [1:0] mode_v,
                                input logic [1:0] act_v, input logic [7:0] cnt,
                                output t_led_result res);
        logic lit;
        lit = lit_now;
        res.pin_changed = 1'b0;
        case (kind)
            KIND_TICK: begin
                phase_ticks = phase_ticks + TIME_W'(1);
                flash_ticks = flash_ticks + TIME_W'(1);
                pattern_level(lit);
                res.pin_changed = (lit != lit_now);
                lit_now = lit;
            end
            KIND_MODE: begin
                if (mode_v <= MODE_IDLE && mode_v != mode_now) begin
                    mode_now = mode_v;
                    phase_ticks = '0;
                end
            end
            KIND_ACT: begin
                if (act_v != activity_now) begin
                    activity_now = act_v;
                    phase_ticks = '0;
                end
            end
            default: begin
                flashes_left = FLASH_LEFT_W'({cnt, 1'b1});
                flash_ticks = '0;
            end
        endcase
        res.led_on = lit;
        res.pin_level = lit ^ active_low;
    endtask

    task automatic compare_field(input string field, input logic want, input logic seen);
        if (seen !== want) begin
            o_mismatches++;
            $display("%0t: %s expected %0b actual %0b", $time, field, want, seen);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_led_result want;
        t_led_result fresh;
        if (!i_rst_n) begin
            expected_q.delete();
            active_low = 1'b0;
            fast_half = RST_FAST_HALF;
            slow_half = RST_SLOW_HALF;
            idle_len = RST_IDLE_PERIOD;
            blip_len = RST_IDLE_BLIP;
            strobe_len = RST_STROBE_HALF;
            flash_len = RST_FLASH_HALF;
            phase_ticks = '0;
            flash_ticks = '0;
            flashes_left = '0;
            mode_now = MODE_IDLE;
            activity_now = ACT_NONE;
            lit_now = 1'b0;
            o_mismatches = 0;
            o_results = 0;
            o_level_changes = 0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_ACTIVE_LOW:  active_low = i_cfg_data[0];
                    CFG_FAST_HALF:   fast_half = i_cfg_data;
                    CFG_SLOW_HALF:   slow_half = i_cfg_data;
                    CFG_IDLE_PERIOD: idle_len = i_cfg_data;
                    CFG_IDLE_BLIP:   blip_len = i_cfg_data;
                    CFG_STROBE_HALF: strobe_len = i_cfg_data;
                    CFG_FLASH_HALF:  flash_len = i_cfg_data;
                    default: ;
                endcase
            end
            if ($isunknown(i_out_valid)) begin
                o_mismatches++;
                $display("%0t: output valid expected 0 or 1 actual %b", $time, i_out_valid);
            end else if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: result expected none actual %b%b%b", $time,
                             i_led_on, i_pin_level, i_pin_changed);
                end else begin
                    want = expected_q.pop_front();
                    compare_field("led_on", want.led_on, i_led_on);
                    compare_field("pin_level", want.pin_level, i_pin_level);
                    compare_field("pin_changed", want.pin_changed, i_pin_changed);
                    o_results++;
                    if (want.pin_changed) begin
                        o_level_changes++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_item(i_kind, i_mode_value, i_activity_value, i_flash_count, fresh);
                expected_q.push_back(fresh);
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== bench/status_led_pattern_generator_test.sv =====
// Testbench top for the status LED pattern generator: stimulus, handshake pressure and verdict.
module status_led_pattern_generator_test;
    import slpg_pkg::*;

    localparam logic [1:0] MODE_RESERVED = 2'd3;
    localparam int NUM_REGS = int'(CFG_FLASH_HALF) + 1;
    localparam int NUM_SETTINGS = 6;
    localparam int ITEMS_PER_SETTING = 225;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [1:0]            i_kind;
    logic [1:0]            i_mode_value;
    logic [1:0]            i_activity_value;
    logic [7:0]            i_flash_count;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_led_on;
    logic                  o_pin_level;
    logic                  o_pin_changed;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int mismatches;
    int pending;
    int results;
    int level_changes;

    status_led_pattern_generator uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_mode_value     (i_mode_value),
        .i_activity_value (i_activity_value),
        .i_flash_count    (i_flash_count),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_led_on         (o_led_on),
        .o_pin_level      (o_pin_level),
        .o_pin_changed    (o_pin_changed),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    led_pattern_checker monitor (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_kind           (i_kind),
        .i_mode_value     (i_mode_value),
        .i_activity_value (i_activity_value),
        .i_flash_count    (i_flash_count),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_led_on         (o_led_on),
        .i_pin_level      (o_pin_level),
        .i_pin_changed    (o_pin_changed),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_results        (results),
        .o_level_changes  (level_changes)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int seg_len;
        int stall_pct;
        i_out_stall <= 1'b0;
        forever begin
            seg_len = $urandom_range(1, 64);
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 25;
                2: stall_pct = 50;
                default: stall_pct = 90;
            endcase
            repeat (seg_len) begin
                @(posedge i_clk);
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [1:0] mode_v,
                             input logic [1:0] act_v, input logic [7:0] cnt);
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_mode_value <= mode_v;
        i_activity_value <= act_v;
        i_flash_count <= cnt;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_directed(input logic [1:0] kind, input logic [7:0] value);
        logic [1:0] mode_v;
        logic [1:0] act_v;
        logic [7:0] cnt;
        mode_v = (kind == KIND_MODE) ? value[1:0] : 2'($urandom);
        act_v = (kind == KIND_ACT) ? value[1:0] : 2'($urandom);
        cnt = (kind == KIND_FLASH) ? value : 8'($urandom);
        send_item(kind, mode_v, act_v, cnt);
    endtask

    task automatic send_random();
        logic [1:0] kind;
        logic [1:0] mode_v;
        logic [1:0] act_v;
        logic [7:0] cnt;
        int pick;
        pick = $urandom_range(0, 99);
        mode_v = 2'($urandom);
        act_v = 2'($urandom);
        cnt = 8'($urandom);
        if (pick < 72) begin
            kind = KIND_TICK;
        end else if (pick < 82) begin
            kind = KIND_MODE;
        end else if (pick < 91) begin
            kind = KIND_ACT;
            if ($urandom_range(0, 2) != 0) begin
                act_v = ACT_NONE;
            end
        end else begin
            kind = KIND_FLASH;
            if ($urandom_range(0, 9) != 0) begin
                cnt = 8'($urandom_range(0, 4));
            end
        end
        send_item(kind, mode_v, act_v, cnt);
    endtask

    task automatic wait_drained(input int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic program_setting(input int setting);
        logic [CFG_DATA_W-1:0] values [NUM_REGS];
        case (setting)
            0: begin
                values[CFG_ACTIVE_LOW] = CFG_DATA_W'(1);
                values[CFG_FAST_HALF] = CFG_DATA_W'(1);
                values[CFG_SLOW_HALF] = CFG_DATA_W'(1);
                values[CFG_IDLE_PERIOD] = CFG_DATA_W'(1);
                values[CFG_IDLE_BLIP] = CFG_DATA_W'(1);
                values[CFG_STROBE_HALF] = CFG_DATA_W'(1);
                values[CFG_FLASH_HALF] = CFG_DATA_W'(1);
            end
            1: begin
                foreach (values[i]) values[i] = '0;
            end
            2: begin
                foreach (values[i]) values[i] = '1;
            end
            default: begin
                values[CFG_ACTIVE_LOW] = CFG_DATA_W'($urandom_range(0, 1));
                values[CFG_FAST_HALF] = CFG_DATA_W'($urandom_range(1, 6));
                values[CFG_SLOW_HALF] = CFG_DATA_W'($urandom_range(1, 12));
                values[CFG_IDLE_PERIOD] = CFG_DATA_W'($urandom_range(1, 16));
                values[CFG_IDLE_BLIP] =
                    CFG_DATA_W'($urandom_range(0, int'(values[CFG_IDLE_PERIOD]) + 1));
                values[CFG_STROBE_HALF] = CFG_DATA_W'($urandom_range(1, 5));
                values[CFG_FLASH_HALF] = CFG_DATA_W'($urandom_range(0, 4));
            end
        endcase
        for (int idx = 0; idx < NUM_REGS; idx++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(idx);
            i_cfg_data <= values[idx];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        int burst_left;
        bit steady;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_kind <= KIND_TICK;
        i_mode_value <= MODE_IDLE;
        i_activity_value <= ACT_NONE;
        i_flash_count <= '0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_ACTIVE_LOW;
        i_cfg_data <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed(KIND_TICK, 8'd0);
        send_directed(KIND_MODE, 8'(MODE_IDLE));
        send_directed(KIND_MODE, 8'(MODE_RESERVED));
        send_directed(KIND_MODE, 8'(MODE_NETWORK));
        send_directed(KIND_TICK, 8'd0);
        send_directed(KIND_MODE, 8'(MODE_SERVER));
        send_directed(KIND_TICK, 8'd0);
        send_directed(KIND_ACT, 8'(ACT_BUTTON));
        send_directed(KIND_TICK, 8'd0);
        send_directed(KIND_ACT, 8'(ACT_SHORT));
        send_directed(KIND_TICK, 8'd0);
        send_directed(KIND_ACT, 8'(ACT_LONG));
        send_directed(KIND_ACT, 8'(ACT_LONG));
        send_directed(KIND_TICK, 8'd0);
        send_directed(KIND_ACT, 8'(ACT_NONE));
        send_directed(KIND_FLASH, 8'd255);
        send_directed(KIND_TICK, 8'd0);
        send_directed(KIND_FLASH, 8'd0);
        send_directed(KIND_TICK, 8'd0);
        send_directed(KIND_FLASH, 8'd1);
        send_directed(KIND_TICK, 8'd0);
        send_directed(KIND_MODE, 8'(MODE_IDLE));
        send_directed(KIND_TICK, 8'd0);

        for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
            wait_drained(4);
            program_setting(setting);
            steady = (setting % 2) == 1;
            burst_left = steady ? 200 : $urandom_range(1, 16);
            repeat (ITEMS_PER_SETTING) begin
                send_random();
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = steady ? 200 : $urandom_range(1, 16);
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
            end
        end

        wait_drained(40);
        $display("Checked %0d LED results over %0d register settings, with %0d level changes.",
                 results, NUM_SETTINGS + 1, level_changes);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
